[design/alss_pkg.sv]
// types, constants and codes shared by the alignment site summarizer
`timescale 1ns / 1ps

package alss_pkg;

  localparam int STATE_W = 8;
  localparam int FREQ_W = 24;
  localparam int SUM_W = 40;
  localparam int COUNT_W = 24;
  localparam int DEF_STATE_BITS = 8;
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic OP_STATE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_CONST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_BORING = 1'b1;

  typedef struct packed {
    logic               op;
    logic [STATE_W-1:0] state_value;
    logic               last_of_site;
    logic               site_is_const;
    logic [FREQ_W-1:0]  site_frequency;
  } in_item_t;

  typedef struct packed {
    logic                is_query_reply;
    logic                site_kept;
    logic [COUNT_W-1:0]  site_index;
    logic [STATE_W-1:0]  site_min;
    logic [STATE_W-1:0]  site_max;
    logic [SUM_W-1:0]    total_frequency;
    logic [SUM_W-1:0]    total_nonconst_frequency;
    logic [STATE_W-1:0]  overall_min;
    logic [STATE_W-1:0]  overall_max;
    logic [COUNT_W-1:0]  kept_count;
    logic [SUM_W-1:0]    const_sum;
  } out_item_t;

  // one classified piece of work for the back end
  typedef struct packed {
    logic               is_query;
    logic [STATE_W-1:0] lo;
    logic [STATE_W-1:0] hi;
    logic               is_const;
    logic [FREQ_W-1:0]  freq;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic keep_const;
    logic keep_boring;
  } cfg_t;

endpackage

[design/alss_front.sv]
// front end: accepts items, folds per-site minimum and maximum, queues finished work
`timescale 1ns / 1ps

module alss_front #(
  parameter int STATE_BITS = alss_pkg::DEF_STATE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  alss_pkg::in_item_t    in_item,
  input  logic                  hold,
  input  alss_pkg::queue_stat_t q_stat,
  output logic                  push,
  output alss_pkg::job_t        push_job
);
  import alss_pkg::*;

  localparam int SB = (STATE_BITS < STATE_W) ? STATE_BITS : STATE_W;

  logic               in_site;
  logic [STATE_W-1:0] cur_min;
  logic [STATE_W-1:0] cur_max;
  logic [STATE_W-1:0] st;
  logic [STATE_W-1:0] fold_min;
  logic [STATE_W-1:0] fold_max;
  logic               accept;
  logic               is_query;

  assign in_ready = !q_stat.full && !hold;
  assign accept = in_valid && in_ready;
  assign is_query = (in_item.op == OP_QUERY);
  assign st = STATE_W'(in_item.state_value[SB-1:0]);

  always_comb begin
    fold_min = st;
    fold_max = st;
    if (in_site) begin
      fold_min = (st < cur_min) ? st : cur_min;
      fold_max = (st > cur_max) ? st : cur_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_site <= 1'b0;
    end else if (accept && !is_query) begin
      in_site <= !in_item.last_of_site;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_query) begin
      cur_min <= fold_min;
      cur_max <= fold_max;
    end
  end

  assign push = accept && (is_query || in_item.last_of_site);

  always_comb begin
    push_job.is_query = is_query;
    push_job.lo = is_query ? st : fold_min;
    push_job.hi = fold_max;
    push_job.is_const = in_item.site_is_const;
    push_job.freq = in_item.site_frequency;
  end

endmodule

[design/alss_queue.sv]
// short queue of classified work between front and back end
`timescale 1ns / 1ps

module alss_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  alss_pkg::job_t        push_job,
  input  logic                  pop,
  output alss_pkg::job_t        head,
  output alss_pkg::queue_stat_t q_stat
);
  import alss_pkg::*;

  job_t            slots [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;

  assign head = slots[rd_ptr];
  assign q_stat.full = (count == (QA_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && q_stat.full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && q_stat.empty))
    else $error("queue read while empty");
`endif

endmodule

[design/alss_back.sv]
// back end: site statistics, constant-site table and result register
`timescale 1ns / 1ps

module alss_back #(
  parameter int TABLE_DEPTH = alss_pkg::DEF_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  alss_pkg::cfg_t        cfg,
  input  alss_pkg::job_t        head,
  input  alss_pkg::queue_stat_t q_stat,
  output logic                  pop,
  output logic                  clr_busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output alss_pkg::out_item_t   out_item
);
  import alss_pkg::*;

  localparam int TBL_AW = $clog2(TABLE_DEPTH);

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [FREQ_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // running statistics
  logic [COUNT_W-1:0] site_counter, site_counter_next;
  logic [SUM_W-1:0]   sum_all, sum_all_next;
  logic [SUM_W-1:0]   sum_nonconst, sum_nonconst_next;
  logic [STATE_W-1:0] kept_min, kept_min_next;
  logic [STATE_W-1:0] kept_max, kept_max_next;
  logic [COUNT_W-1:0] kept_total, kept_total_next;

  // table and clearing pass
  logic [SUM_W-1:0]   mem [TABLE_DEPTH];
  logic [SUM_W-1:0]   mem_q;
  logic               mem_we;
  logic [TBL_AW-1:0]  mem_wa;
  logic [SUM_W-1:0]   mem_wd;
  logic [TBL_AW-1:0]  clr_cnt;

  // pop side
  logic [31:0]        lo_wide;
  logic [TBL_AW-1:0]  pop_addr;
  logic               pop_in_range;
  logic               kept;
  logic               pop_upd;
  out_item_t          pop_res;

  // second stage
  logic               s1_valid;
  logic               s1_adv;
  out_item_t          s1_res;
  out_item_t          s1_out;
  logic               s1_upd;
  logic               s1_in_range;
  logic [TBL_AW-1:0]  s1_addr;
  logic [FREQ_W-1:0]  s1_freq;
  logic               fwd_hit;
  logic [SUM_W-1:0]   fwd_data;
  logic [SUM_W-1:0]   base;
  logic [SUM_W-1:0]   upd_sum;
  logic               tbl_we;

  assign s1_adv = s1_valid && (!out_valid || out_ready);
  assign pop = !q_stat.empty && !clr_busy && (!s1_valid || s1_adv);

  assign lo_wide = 32'(head.lo);
  assign pop_addr = lo_wide[TBL_AW-1:0];
  assign pop_in_range = (lo_wide < 32'(TABLE_DEPTH));

  always_comb begin
    site_counter_next = site_counter;
    sum_all_next = sum_all;
    sum_nonconst_next = sum_nonconst;
    kept_min_next = kept_min;
    kept_max_next = kept_max;
    kept_total_next = kept_total;
    kept = (cfg.keep_const || !head.is_const) &&
           (cfg.keep_boring || ((head.freq != '0) && (head.lo < head.hi)));
    pop_upd = !head.is_query && !kept && (head.lo == head.hi) && pop_in_range;
    if (pop && !head.is_query) begin
      site_counter_next = site_counter + 1'b1;
      sum_all_next = sat_add(sum_all, head.freq);
      if (!head.is_const) begin
        sum_nonconst_next = sat_add(sum_nonconst, head.freq);
      end
      if (kept) begin
        if (kept_total == '0) begin
          kept_min_next = head.lo;
          kept_max_next = head.hi;
        end else begin
          kept_min_next = (head.lo < kept_min) ? head.lo : kept_min;
          kept_max_next = (head.hi > kept_max) ? head.hi : kept_max;
        end
        if (kept_total != {COUNT_W{1'b1}}) begin
          kept_total_next = kept_total + 1'b1;
        end
      end
    end
  end

  always_comb begin
    pop_res.is_query_reply = head.is_query;
    pop_res.site_kept = head.is_query ? 1'b0 : kept;
    pop_res.site_index = head.is_query ? '0 : site_counter;
    pop_res.site_min = head.is_query ? '0 : head.lo;
    pop_res.site_max = head.is_query ? '0 : head.hi;
    pop_res.total_frequency = sum_all_next;
    pop_res.total_nonconst_frequency = sum_nonconst_next;
    pop_res.overall_min = kept_min_next;
    pop_res.overall_max = kept_max_next;
    pop_res.kept_count = kept_total_next;
    pop_res.const_sum = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      site_counter <= '0;
      sum_all <= '0;
      sum_nonconst <= '0;
      kept_min <= '0;
      kept_max <= '0;
      kept_total <= '0;
    end else begin
      site_counter <= site_counter_next;
      sum_all <= sum_all_next;
      sum_nonconst <= sum_nonconst_next;
      kept_min <= kept_min_next;
      kept_max <= kept_max_next;
      kept_total <= kept_total_next;
    end
  end

  // read-modify-write of the table entry
  assign base = fwd_hit ? fwd_data : mem_q;
  assign upd_sum = sat_add(base, s1_freq);
  assign tbl_we = s1_adv && s1_upd;

  assign mem_we = clr_busy || tbl_we;
  assign mem_wa = clr_busy ? clr_cnt : s1_addr;
  assign mem_wd = clr_busy ? '0 : upd_sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mem_q <= mem[pop_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt <= '0;
    end else if (clr_busy) begin
      if (clr_cnt == TBL_AW'(TABLE_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_res <= pop_res;
      s1_upd <= pop_upd;
      s1_in_range <= pop_in_range;
      s1_addr <= pop_addr;
      s1_freq <= head.freq;
      // entry written at this same edge
      fwd_hit <= tbl_we && (s1_addr == pop_addr);
      fwd_data <= upd_sum;
    end
  end

  always_comb begin
    s1_out = s1_res;
    s1_out.const_sum = (s1_res.is_query_reply && s1_in_range) ? base : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= s1_out;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst) !(pop && clr_busy))
    else $error("work taken during table clearing");
  a_no_write_clearing: assert property (@(posedge clk) disable iff (rst)
    !(tbl_we && clr_busy))
    else $error("table update during clearing");
  a_kept_monotone: assert property (@(posedge clk) disable iff (rst)
    !clr_busy |=> kept_total >= $past(kept_total))
    else $error("kept count went down");
`endif

endmodule

[design/alignment_site_summarizer.sv]
// top level of the alignment site summarizer
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   input    | in_valid / in_ready      | in_item  (alss_pkg::in_item_t)
//   output   | out_valid / out_ready    | out_item (alss_pkg::out_item_t)
//   config   | cfg_wr_en                | cfg_index, cfg_data
//
// one item per cycle sustained unless the output stalls or the table is clearing; each item
// passes queue, table read, result register; the table read-modify-write is the pacing path
// after reset the table clears one entry a cycle with in_ready low; a stalled output fills
// the result register, then the table stage, then the four-entry queue; configuration writes
// apply at the next edge; the user makes them only while no item is in flight, unchecked
`timescale 1ns / 1ps

module alignment_site_summarizer #(
  parameter int STATE_BITS = alss_pkg::DEF_STATE_BITS,
  parameter int TABLE_DEPTH = alss_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  alss_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output alss_pkg::out_item_t                  out_item,
  input  logic                                 cfg_wr_en,
  input  logic [alss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [alss_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import alss_pkg::*;

  cfg_t        cfg;
  queue_stat_t q_stat;
  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        head;
  logic        clr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEEP_CONST:  cfg.keep_const <= cfg_data[0];
        CFG_KEEP_BORING: cfg.keep_boring <= cfg_data[0];
        default: ;
      endcase
    end
  end

  alss_front #(
    .STATE_BITS (STATE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .hold     (clr_busy),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  alss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  alss_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
